// ===== rtl/core/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    localparam int unsigned CNT_W      = 32;  // payload length counter width, 16..63
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW       = $clog2(Q_DEPTH + 1);
    localparam logic [31:0] MAX_LEN_RST = 32'd16777216;

    localparam logic [7:0] FIN_BIT  = 8'h80;
    localparam logic [7:0] OP_MASK  = 8'h0F;
    localparam logic [7:0] LEN_MASK = 8'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              fin;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  len;
        logic [7:0]        data;
        logic [31:0]       key;
        logic              last;
    } cmd_t;

endpackage

// ===== rtl/core/wsdf_front.sv =====
// Header parser: classifies each incoming byte and issues commands to the queue.
module wsdf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             q_ready,
    output logic             q_push,
    output wsdf_pkg::cmd_t   q_cmd
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_B0   = 3'd0,
        PH_B1   = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               fin_reg, fin_next;
    logic [3:0]         opcode_reg, opcode_next;
    logic               masked_reg, masked_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [31:0]        key_reg, key_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [31:0]        max_reg;

    logic               take_len;
    logic               take_hdr;
    logic               too_big;
    logic [ACC_W-1:0]   len_v;
    logic               masked_v;
    logic [31:0]        key_v;
    logic [6:0]         l7;
    logic [CNT_W-1:0]   rem_dec;

    assign s_ready = q_ready;
    assign l7      = 7'(s_data_byte & LEN_MASK);
    assign rem_dec = rem_reg - CNT_W'(1);

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        take_len    = 1'b0;
        take_hdr    = 1'b0;
        too_big     = 1'b0;
        len_v       = acc_reg;
        masked_v    = masked_reg;
        key_v       = key_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        q_cmd.fin    = fin_reg;
        q_cmd.opcode = opcode_reg;
        q_cmd.masked = masked_reg;

        if (s_valid && s_ready) begin
            unique case (phase_reg)
                PH_B0: begin
                    fin_next    = (s_data_byte & FIN_BIT) != 8'h00;
                    opcode_next = 4'(s_data_byte & OP_MASK);
                    phase_next  = PH_B1;
                end
                PH_B1: begin
                    masked_v    = s_data_byte[7];
                    masked_next = masked_v;
                    if (l7 == LEN_EXT16 || l7 == LEN_EXT64) begin
                        acc_next   = '0;
                        cnt_next   = (l7 == LEN_EXT16) ? 4'd2 : 4'd8;
                        phase_next = PH_EXT;
                    end else begin
                        len_v    = ACC_W'(l7);
                        acc_next = len_v;
                        take_len = 1'b1;
                    end
                end
                PH_EXT: begin
                    len_v    = {acc_reg[ACC_W-9:0], s_data_byte};
                    acc_next = len_v;
                    cnt_next = cnt_reg - 4'd1;
                    take_len = (cnt_reg == 4'd1);
                end
                PH_KEY: begin
                    key_v    = {key_reg[23:0], s_data_byte};
                    key_next = key_v;
                    cnt_next = cnt_reg - 4'd1;
                    take_hdr = (cnt_reg == 4'd1);
                end
                PH_DATA: begin
                    rem_next    = rem_dec;
                    q_push      = 1'b1;
                    q_cmd.kind  = KIND_DATA;
                    q_cmd.data  = s_data_byte;
                    q_cmd.last  = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        phase_next = PH_B0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (take_len) begin
            too_big = (len_v[ACC_W-1:CNT_W] != '0) || (len_v > {32'b0, max_reg});
            if (too_big) begin
                q_push       = 1'b1;
                q_cmd.kind   = KIND_ERR;
                q_cmd.masked = masked_v;
                q_cmd.len    = (len_v[ACC_W-1:LEN_W] != '0) ? '1 : len_v[LEN_W-1:0];
                q_cmd.last   = 1'b1;
                phase_next   = PH_DROP;
            end else if (masked_v) begin
                cnt_next   = 4'd4;
                key_next   = '0;
                phase_next = PH_KEY;
            end else begin
                take_hdr = 1'b1;
            end
        end

        if (take_hdr) begin
            q_push       = 1'b1;
            q_cmd.kind   = KIND_HDR;
            q_cmd.masked = masked_v;
            q_cmd.len    = LEN_W'(len_v);
            q_cmd.key    = masked_v ? key_v : '0;
            q_cmd.last   = (len_v == '0);
            rem_next     = len_v[CNT_W-1:0];
            phase_next   = (len_v == '0) ? PH_B0 : PH_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_B0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
            max_reg    <= MAX_LEN_RST;
        end else begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/core/wsdf_queue.sv =====
// Small command queue between the header parser and the output stage.
module wsdf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wsdf_pkg::cmd_t   push_cmd,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output wsdf_pkg::cmd_t   pop_cmd
);
    import wsdf_pkg::*;

    cmd_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + Q_CW'(1)))
        else $error("queue count did not grow on push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != Q_CW'(Q_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg + Q_AW'(count_reg)))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/core/wsdf_back.sv =====
// Output stage: unmasks payload beats and holds the result register.
module wsdf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  wsdf_pkg::cmd_t   q_cmd,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic             m_fin,
    output logic [3:0]       m_opcode,
    output logic             m_masked,
    output logic [31:0]      m_payload_length,
    output logic [7:0]       m_payload_byte,
    output logic             m_last
);
    import wsdf_pkg::*;

    logic               valid_reg;
    kind_t              kind_reg;
    logic               fin_reg;
    logic [3:0]         opcode_reg;
    logic               masked_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    logic [31:0]        key_reg;
    logic [1:0]         idx_reg;
    logic [7:0]         key_byte;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            key_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (q_pop && q_cmd.kind == KIND_HDR) begin
                key_reg <= q_cmd.key;
                idx_reg <= '0;
            end else if (q_pop && q_cmd.kind == KIND_DATA) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= q_cmd.kind;
            fin_reg    <= q_cmd.fin;
            opcode_reg <= q_cmd.opcode;
            masked_reg <= q_cmd.masked;
            len_reg    <= q_cmd.len;
            byte_reg   <= (q_cmd.kind == KIND_DATA) ? (q_cmd.data ^ key_byte) : 8'h00;
            last_reg   <= q_cmd.last;
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = kind_reg;
    assign m_fin            = fin_reg;
    assign m_opcode         = opcode_reg;
    assign m_masked         = masked_reg;
    assign m_payload_length = len_reg;
    assign m_payload_byte   = byte_reg;
    assign m_last           = last_reg;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// WebSocket frame deframer top level: parser, command queue and output stage.
// A result passes through the command queue and the output register before it appears on m_*.
// Throughput: one input beat per cycle while the command queue has room; parser and output stall independently.
// The four-entry command queue sets how long the input keeps flowing under m_ready low.
// Reset (aresetn low, synchronous) returns to the first header byte, empties the queue,
// and sets max_payload_length to 16777216.
module websocket_frame_deframer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_kind,
    output logic         m_fin,
    output logic [3:0]   m_opcode,
    output logic         m_masked,
    output logic [31:0]  m_payload_length,
    output logic [7:0]   m_payload_byte,
    output logic         m_last
);
    import wsdf_pkg::*;

    logic  q_push;
    logic  q_ready;
    cmd_t  q_push_cmd;
    logic  q_pop;
    logic  q_valid;
    cmd_t  q_pop_cmd;

    wsdf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd)
    );

    wsdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_pop_cmd)
    );

    wsdf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_cmd            (q_pop_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fin            (m_fin),
        .m_opcode         (m_opcode),
        .m_masked         (m_masked),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last)
    );

endmodule

// ===== tb/wsdf_frame_checker.sv =====
// Scoreboard for the WebSocket frame deframer: predicts results from input beats and compares.
module wsdf_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic        m_fin,
    input  logic [3:0]  m_opcode,
    input  logic        m_masked,
    input  logic [31:0] m_payload_length,
    input  logic [7:0]  m_payload_byte,
    input  logic        m_last,
    output int          mismatches,
    output int          pending,
    output int          beats_in,
    output int          headers_seen,
    output int          payload_seen,
    output int          errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_SECOND,
        ST_EXTLEN,
        ST_KEY,
        ST_PAYLOAD,
        ST_DISCARD
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [31:0] len;
        logic [7:0]  data;
        logic        last;
    } frame_result_t;

    localparam logic [63:0] COUNT_MAX = (64'd1 << CNT_W) - 64'd1;

    parse_state_t  state_q;
    logic          fin_q;
    logic [3:0]    opcode_q;
    logic          mask_q;
    logic [63:0]   length_q;
    logic [3:0]    hdr_left_q;
    logic [31:0]   key_q;
    logic [63:0]   remaining_q;
    logic [1:0]    key_idx_q;
    logic [31:0]   max_len_q;
    frame_result_t results_due[$];

    function automatic void push_result(kind_t k, logic [31:0] len, logic [7:0] pb, logic lst);
        frame_result_t r;
        r.kind   = k;
        r.fin    = fin_q;
        r.opcode = opcode_q;
        r.masked = mask_q;
        r.len    = len;
        r.data   = pb;
        r.last   = lst;
        results_due = {results_due, r};
    endfunction

    function automatic void header_finish();
        push_result(KIND_HDR, length_q[31:0], 8'h00, length_q == 64'd0);
        remaining_q = length_q;
        key_idx_q   = 2'd0;
        state_q     = (length_q == 64'd0) ? ST_FIRST : ST_PAYLOAD;
    endfunction

    function automatic void length_known();
        if (length_q > {32'd0, max_len_q} || length_q > COUNT_MAX) begin
            push_result(KIND_ERR, (length_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : length_q[31:0],
                        8'h00, 1'b1);
            state_q = ST_DISCARD;
        end else if (mask_q) begin
            hdr_left_q = 4'd4;
            key_q      = '0;
            state_q    = ST_KEY;
        end else begin
            header_finish();
        end
    endfunction

    always @(posedge aclk) begin
        frame_result_t exp_r;
        frame_result_t act_r;
        logic [6:0]    len7;
        logic [7:0]    kb;
        if (!aresetn) begin
            state_q     = ST_FIRST;
            fin_q       = 1'b0;
            opcode_q    = '0;
            mask_q      = 1'b0;
            length_q    = '0;
            hdr_left_q  = '0;
            key_q       = '0;
            remaining_q = '0;
            key_idx_q   = '0;
            max_len_q   = MAX_LEN_RST;
            results_due.delete();
            mismatches   = 0;
            beats_in     = 0;
            headers_seen = 0;
            payload_seen = 0;
            errors_seen  = 0;
        end else begin
            if (cfg_we) begin
                max_len_q = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                beats_in++;
                case (state_q)
                    ST_FIRST: begin
                        fin_q    = |(s_data_byte & FIN_BIT);
                        opcode_q = 4'(s_data_byte & OP_MASK);
                        state_q  = ST_SECOND;
                    end
                    ST_SECOND: begin
                        mask_q = |(s_data_byte & FIN_BIT);
                        len7   = 7'(s_data_byte & LEN_MASK);
                        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                            length_q   = '0;
                            hdr_left_q = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
                            state_q    = ST_EXTLEN;
                        end else begin
                            length_q = 64'(len7);
                            length_known();
                        end
                    end
                    ST_EXTLEN: begin
                        length_q   = {length_q[55:0], s_data_byte};
                        hdr_left_q = hdr_left_q - 4'd1;
                        if (hdr_left_q == 4'd0) begin
                            length_known();
                        end
                    end
                    ST_KEY: begin
                        key_q      = {key_q[23:0], s_data_byte};
                        hdr_left_q = hdr_left_q - 4'd1;
                        if (hdr_left_q == 4'd0) begin
                            header_finish();
                        end
                    end
                    ST_PAYLOAD: begin
                        kb          = mask_q ? key_q[8*(3-key_idx_q) +: 8] : 8'h00;
                        key_idx_q   = key_idx_q + 2'd1;
                        remaining_q = remaining_q - 64'd1;
                        push_result(KIND_DATA, 32'd0, s_data_byte ^ kb, remaining_q == 64'd0);
                        if (remaining_q == 64'd0) begin
                            state_q = ST_FIRST;
                        end
                    end
                    default: ;  // discard until reset
                endcase
            end
            if (m_valid && m_ready) begin
                act_r.kind   = kind_t'(m_kind);
                act_r.fin    = m_fin;
                act_r.opcode = m_opcode;
                act_r.masked = m_masked;
                act_r.len    = m_payload_length;
                act_r.data   = m_payload_byte;
                act_r.last   = m_last;
                case (m_kind)
                    KIND_HDR:  headers_seen++;
                    KIND_DATA: payload_seen++;
                    default:   errors_seen++;
                endcase
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result kind %0d fin %0d op %0h masked %0d",
                                 $realtime, m_kind, m_fin, m_opcode, m_masked);
                        $display("    len %0d byte %02h last %0d",
                                 m_payload_length, m_payload_byte, m_last);
                    end
                end else begin
                    exp_r = results_due.pop_front();
                    if (act_r !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp kind %0d fin %0d op %0h masked %0d",
                                     $realtime, exp_r.kind, exp_r.fin, exp_r.opcode,
                                     exp_r.masked);
                            $display("    exp len %0d byte %02h last %0d",
                                     exp_r.len, exp_r.data, exp_r.last);
                            $display("    got kind %0d fin %0d op %0h masked %0d",
                                     m_kind, m_fin, m_opcode, m_masked);
                            $display("    got len %0d byte %02h last %0d",
                                     m_payload_length, m_payload_byte, m_last);
                        end
                    end
                end
            end
        end
        pending = results_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the WebSocket frame deframer: stimulus, flow control and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_kind;
    logic        m_fin;
    logic [3:0]  m_opcode;
    logic        m_masked;
    logic [31:0] m_payload_length;
    logic [7:0]  m_payload_byte;
    logic        m_last;

    int          mismatches;
    int          pending;
    int          beats_in;
    int          headers_seen;
    int          payload_seen;
    int          errors_seen;

    int          s_gap_pct   = 26;
    int          m_stall_pct = 87;
    int          sent        = 0;
    logic [31:0] limit_now   = MAX_LEN_RST;

    websocket_frame_deframer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fin            (m_fin),
        .m_opcode         (m_opcode),
        .m_masked         (m_masked),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last)
    );

    wsdf_frame_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fin            (m_fin),
        .m_opcode         (m_opcode),
        .m_masked         (m_masked),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .pending          (pending),
        .beats_in         (beats_in),
        .headers_seen     (headers_seen),
        .payload_seen     (payload_seen),
        .errors_seen      (errors_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < s_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // hold the input until every expected result is out, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_max(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_now = v;
    endtask

    // one well-formed frame with length at or under the current limit
    task automatic send_frame();
        logic [7:0]  first_b;
        logic [6:0]  len_code;
        logic [63:0] len;
        int          pick;
        int          ext_n;
        bit          msk;
        first_b = 8'($urandom);
        msk     = 1'($urandom_range(1));
        pick    = $urandom_range(99);
        if (pick < 35) begin
            len = 64'($urandom_range(8));
        end else if (pick < 75) begin
            len = 64'($urandom_range(40));
        end else if (pick < 92) begin
            len = 64'($urandom_range(200));
        end else begin
            len = (limit_now <= 300) ? 64'(limit_now) : 64'($urandom_range(300));
        end
        if (len > 64'(limit_now)) begin
            len = 64'(limit_now);
        end
        pick = $urandom_range(9);
        if (len <= 125) begin
            ext_n = (pick == 0) ? 2 : (pick == 1) ? 8 : 0;
        end else if (len <= 65535) begin
            ext_n = (pick < 5) ? 2 : 8;
        end else begin
            ext_n = 8;
        end
        len_code = (ext_n == 0) ? 7'(len) : (ext_n == 2) ? LEN_EXT16 : LEN_EXT64;
        send_byte(first_b);
        send_byte({msk, len_code});
        for (int i = ext_n - 1; i >= 0; i--) begin
            send_byte(len[8*i +: 8]);
        end
        if (msk) begin
            repeat (4) send_byte(8'($urandom));
        end
        for (int i = 0; i < int'(len); i++) begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic send_random(input int budget);
        int stop;
        stop = sent + budget;
        while (sent < stop) begin
            send_frame();
        end
    endtask

    initial begin
        logic [7:0] seq[$];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero-length, masked single byte, short 16-bit extended, non-minimal 64-bit extended
        seq = {8'h8F, 8'h00,
               8'h00, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF,
               8'h71, 8'h7E, 8'h00, 8'h02, 8'h00, 8'hFF,
               8'h82, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};
        foreach (seq[i]) send_byte(seq[i]);

        drain();
        write_max(32'hFFFF_FFFF);
        send_random(300);

        drain();
        s_gap_pct   = 87;
        m_stall_pct = 26;
        write_max(32'd0);
        send_random(40);

        drain();
        write_max(32'd130);
        send_random(300);

        drain();
        s_gap_pct   = 0;
        m_stall_pct = 0;
        write_max(MAX_LEN_RST);
        send_random(260);

        // oversized 64-bit length: one error beat, then the parser discards until reset
        drain();
        write_max(32'd300);
        seq = {8'h81, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
        repeat (12) send_byte(8'($urandom));

        drain();
        repeat (10) @(posedge aclk);
        $display("Covered %0d input beats over six limit settings, 0 and 2^32-1 included",
                 beats_in);
        $display("Checked %0d headers, %0d payload beats, %0d oversize errors",
                 headers_seen, payload_seen, errors_seen);
        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_front.sv
rtl/core/wsdf_queue.sv
rtl/core/wsdf_back.sv
rtl/core/websocket_frame_deframer.sv
tb/wsdf_frame_checker.sv
tb/tb.sv
